FILE: hdl/cyk_binary_grammar_recognizer_unit_macros.svh
// Assertion macros used by the recognizer controller
`ifndef CYK_BINARY_GRAMMAR_RECOGNIZER_UNIT_MACROS_SVH
`define CYK_BINARY_GRAMMAR_RECOGNIZER_UNIT_MACROS_SVH
`ifndef SYNTH
// Check a property on every clock edge outside reset
`define CYK_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("cyk assertion failed");
// Check that a condition leads to another one on the next edge
`define CYK_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("cyk assertion failed");
`else
`define CYK_ASSERT(lbl, prop)
`define CYK_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

FILE: hdl/cyk_pkg.sv
// Shared types, constants and rule-combine function of the CYK recognizer
package cyk_pkg;

  localparam int unsigned SYM_W  = 2;
  localparam int unsigned MASK_W = 4;
  localparam int unsigned RULE_W = 64;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             last;
  } in_item_t;

  typedef struct packed {
    logic [MASK_W-1:0] letter_mask;
    logic              none_possible;
    logic              overflow;
  } out_item_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic leaf_we;   // store a loaded symbol on the diagonal
    logic rd_en;     // read two cells
    logic fill;      // the read belongs to a split point of the fill
    logic first;     // first split point of a cell
    logic last_mid;  // last split point of a cell
    logic out_load;  // load the result register
    logic overflow;  // overflow flag for the result
  } cmd_t;

  // Symbols that rewrite to (some symbol of lm)(some symbol of rm)
  function automatic logic [MASK_W-1:0] combine(logic [RULE_W-1:0] rules,
                                                logic [MASK_W-1:0] lm,
                                                logic [MASK_W-1:0] rm);
    logic [MASK_W-1:0] res;
    res = '0;
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        if (lm[j] && ((rules[i*16 + j*4 +: 4] & rm) != '0)) begin
          res[i] = 1'b1;
        end
      end
    end
    return res;
  endfunction

endpackage

FILE: hdl/cyk_datapath.sv
// Datapath: span table memory, rule register, split-point combine and result register
module cyk_datapath #(
  parameter int unsigned MAX_LEN = 64,
  localparam int unsigned IW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [cyk_pkg::RULE_W-1:0]  cfg_rules_i,
  input  cyk_pkg::cmd_t               cmd_i,
  input  logic [cyk_pkg::SYM_W-1:0]   symbol_i,
  input  logic [IW-1:0]               leaf_idx_i,
  input  logic [IW-1:0]               rd_a_row_i,
  input  logic [IW-1:0]               rd_a_col_i,
  input  logic [IW-1:0]               rd_b_row_i,
  input  logic [IW-1:0]               rd_b_col_i,
  input  logic [IW-1:0]               cell_row_i,
  input  logic [IW-1:0]               cell_col_i,
  output cyk_pkg::out_item_t          out_item_o
);

  localparam int unsigned AW    = 2 * IW;
  localparam int unsigned DEPTH = 1 << AW;

  logic [cyk_pkg::RULE_W-1:0] rules_q;
  logic [cyk_pkg::MASK_W-1:0] mem_q [DEPTH];
  logic [cyk_pkg::MASK_W-1:0] rd_a_q, rd_b_q;
  logic [cyk_pkg::MASK_W-1:0] acc_q, acc_d, comb;
  logic                       p1_valid_q, p1_first_q, p1_last_q;
  logic [AW-1:0]              p1_addr_q;
  logic                       we;
  logic [AW-1:0]              wr_addr;
  logic [cyk_pkg::MASK_W-1:0] wr_data;
  cyk_pkg::out_item_t         out_q;

  // Rule register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rules_q <= '0;
    end else if (cfg_we_i) begin
      rules_q <= cfg_rules_i;
    end
  end

  // Combine the two halves of the current split point and fold into the cell
  always_comb begin
    comb  = cyk_pkg::combine(rules_q, rd_a_q, rd_b_q);
    acc_d = p1_first_q ? comb : (acc_q | comb);
  end

  // Select the single write: a loaded symbol or a finished cell
  always_comb begin
    if (cmd_i.leaf_we) begin
      we      = 1'b1;
      wr_addr = {leaf_idx_i, leaf_idx_i};
      wr_data = cyk_pkg::MASK_W'(1) << symbol_i;
    end else begin
      we      = p1_valid_q && p1_last_q;
      wr_addr = p1_addr_q;
      wr_data = acc_d;
    end
  end

  // Span table memory: one write, two registered reads
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      rd_a_q <= mem_q[{rd_a_row_i, rd_a_col_i}];
      rd_b_q <= mem_q[{rd_b_row_i, rd_b_col_i}];
    end
  end

  // Split-point stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_valid_q <= 1'b0;
    end else begin
      p1_valid_q <= cmd_i.rd_en && cmd_i.fill;
    end
  end

  // Split-point stage payload and accumulator
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      p1_first_q <= cmd_i.first;
      p1_last_q  <= cmd_i.last_mid;
      p1_addr_q  <= {cell_row_i, cell_col_i};
    end
    if (p1_valid_q) begin
      acc_q <= acc_d;
    end
  end

  // Result register, loaded from the whole-string cell
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.letter_mask   <= rd_a_q;
      out_q.none_possible <= (rd_a_q == '0);
      out_q.overflow      <= cmd_i.overflow;
    end
  end

  assign out_item_o = out_q;

endmodule

FILE: hdl/cyk_ctrl.sv
// Controller: symbol loading, span/left/midpoint walk and result handshake
`include "cyk_binary_grammar_recognizer_unit_macros.svh"
module cyk_ctrl #(
  parameter int unsigned MAX_LEN = 64,
  localparam int unsigned IW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_last_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output cyk_pkg::cmd_t cmd_o,
  output logic [IW-1:0] leaf_idx_o,
  output logic [IW-1:0] rd_a_row_o,
  output logic [IW-1:0] rd_a_col_o,
  output logic [IW-1:0] rd_b_row_o,
  output logic [IW-1:0] rd_b_col_o,
  output logic [IW-1:0] cell_row_o,
  output logic [IW-1:0] cell_col_o
);

  localparam int unsigned CW = $clog2(MAX_LEN + 1);

  typedef enum logic [2:0] {
    S_LOAD,
    S_FILL,
    S_GAP,
    S_RD,
    S_RES
  } state_e;

  state_e        state_q;
  logic [CW-1:0] cnt_q;
  logic          ovf_q;
  logic [IW-1:0] len_q, left_q, mid_q, last_idx_q;
  logic          out_valid_q;
  logic [IW-1:0] right, mid_nx, n_minus1;
  logic          in_accept, store, out_free;

  assign right     = left_q + len_q;
  assign mid_nx    = mid_q + IW'(1);
  assign in_accept = in_valid_i && (state_q == S_LOAD);
  assign store     = in_accept && (cnt_q < CW'(MAX_LEN));
  assign n_minus1  = store ? cnt_q[IW-1:0] : IW'(MAX_LEN - 1);
  assign out_free  = !out_valid_q || !out_stall_i;

  assign in_stall_o  = (state_q != S_LOAD);
  assign out_valid_o = out_valid_q;

  // Drive commands and addresses
  always_comb begin
    cmd_o.leaf_we  = store;
    cmd_o.rd_en    = (state_q == S_FILL) || (state_q == S_RD);
    cmd_o.fill     = (state_q == S_FILL);
    cmd_o.first    = (mid_q == left_q);
    cmd_o.last_mid = (mid_nx == right);
    cmd_o.out_load = (state_q == S_RES) && out_free;
    cmd_o.overflow = ovf_q;
    leaf_idx_o     = cnt_q[IW-1:0];
    rd_a_row_o     = (state_q == S_RD) ? '0 : left_q;
    rd_a_col_o     = (state_q == S_RD) ? last_idx_q : mid_q;
    rd_b_row_o     = mid_nx;
    rd_b_col_o     = right;
    cell_row_o     = left_q;
    cell_col_o     = right;
  end

  // State, counters and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      len_q       <= '0;
      left_q      <= '0;
      mid_q       <= '0;
      last_idx_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // drop the result once taken, unless a new one replaces it
      if (out_valid_q && !out_stall_i && !cmd_o.out_load) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_LOAD: begin
          if (in_accept) begin
            if (!store) begin
              ovf_q <= 1'b1;
            end
            if (in_last_i) begin
              cnt_q      <= '0;
              last_idx_q <= n_minus1;
              len_q      <= IW'(1);
              left_q     <= '0;
              mid_q      <= '0;
              state_q    <= (n_minus1 == '0) ? S_RD : S_FILL;
            end else if (store) begin
              cnt_q <= cnt_q + CW'(1);
            end
          end
        end
        S_FILL: begin
          if (mid_nx == right) begin
            if (right == last_idx_q) begin
              state_q <= S_GAP;
            end else begin
              left_q <= left_q + IW'(1);
              mid_q  <= left_q + IW'(1);
            end
          end else begin
            mid_q <= mid_nx;
          end
        end
        S_GAP: begin
          // let the last cell of this span land before the next span reads it
          if (len_q == last_idx_q) begin
            state_q <= S_RD;
          end else begin
            len_q   <= len_q + IW'(1);
            left_q  <= '0;
            mid_q   <= '0;
            state_q <= S_FILL;
          end
        end
        S_RD: begin
          state_q <= S_RES;
        end
        S_RES: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            ovf_q       <= 1'b0;
            state_q     <= S_LOAD;
          end
        end
        default: begin
          state_q <= S_LOAD;
        end
      endcase
    end
  end

  `CYK_ASSERT(a_mid_in_span, (state_q == S_FILL) |-> (mid_q >= left_q && mid_q < right))
  `CYK_ASSERT(a_cell_in_string, (state_q == S_FILL) |-> (right <= last_idx_q))
  `CYK_ASSERT(a_no_result_clobber, cmd_o.out_load |-> !(out_valid_q && out_stall_i))
  `CYK_ASSERT(a_count_bound, cnt_q <= CW'(MAX_LEN))
  `CYK_ASSERT_NEXT(a_gap_after_fill, (state_q == S_FILL) && (mid_nx == right) && (right == last_idx_q), state_q == S_GAP)

endmodule

FILE: hdl/cyk_binary_grammar_recognizer_unit.sv
// CYK binary grammar recognizer: top level joining controller and datapath
// Symbols load one per cycle; no result until the symbol marked last.
// After last, a string of n stored symbols (n <= MAX_LEN) is worked through by
// split-point reads (one midpoint per cycle), span-change gaps, a final read and the result.
// Input is stalled from the last symbol until the result sits in the output register.
// Asynchronous active-low reset clears control state and the rule register to zero.
module cyk_binary_grammar_recognizer_unit #(
  parameter int unsigned MAX_LEN = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [cyk_pkg::RULE_W-1:0] cfg_rule_table_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  cyk_pkg::in_item_t          in_item_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output cyk_pkg::out_item_t         out_item_o
);

  localparam int unsigned IW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

  cyk_pkg::cmd_t cmd;
  logic [IW-1:0] leaf_idx, rd_a_row, rd_a_col, rd_b_row, rd_b_col, cell_row, cell_col;

  assign cfg_ready_o = 1'b1;

  cyk_ctrl #(
    .MAX_LEN(MAX_LEN)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_last_i  (in_item_i.last),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .cmd_o      (cmd),
    .leaf_idx_o (leaf_idx),
    .rd_a_row_o (rd_a_row),
    .rd_a_col_o (rd_a_col),
    .rd_b_row_o (rd_b_row),
    .rd_b_col_o (rd_b_col),
    .cell_row_o (cell_row),
    .cell_col_o (cell_col)
  );

  cyk_datapath #(
    .MAX_LEN(MAX_LEN)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_rules_i(cfg_rule_table_i),
    .cmd_i      (cmd),
    .symbol_i   (in_item_i.symbol),
    .leaf_idx_i (leaf_idx),
    .rd_a_row_i (rd_a_row),
    .rd_a_col_i (rd_a_col),
    .rd_b_row_i (rd_b_row),
    .rd_b_col_i (rd_b_col),
    .cell_row_i (cell_row),
    .cell_col_i (cell_col),
    .out_item_o (out_item_o)
  );

endmodule

FILE: sim/tb.sv
// Self-checking testbench for the CYK binary grammar recognizer unit
`timescale 1ns / 100ps

module tb;

  localparam int unsigned MAX_SYMS     = 64;
  localparam int unsigned ITEM_TARGET  = 1300;
  localparam int unsigned RAND_PHASES  = 6;
  localparam int unsigned CYCLE_LIMIT  = 2_000_000;
  localparam int unsigned HOLD_CYCLES  = 600;
  localparam int unsigned HOLD_AFTER   = 40;
  localparam int unsigned SETTLE       = 8;

  // Alphabet codes
  localparam logic [1:0] LTR_W = 2'd0;
  localparam logic [1:0] LTR_I = 2'd1;
  localparam logic [1:0] LTR_N = 2'd2;
  localparam logic [1:0] LTR_G = 2'd3;

  // Predict and check the whole-string verdict of each string
  class verdict_board;
    logic [cyk_pkg::RULE_W-1:0] rules;
    logic [cyk_pkg::MASK_W-1:0] span [MAX_SYMS][MAX_SYMS];
    int unsigned                loaded;
    bit                         dropped;
    cyk_pkg::out_item_t         verdict_q [$];
    int unsigned                errors;
    int unsigned                checked;
    int unsigned                strings;
    int unsigned                overflows;

    function new();
      rules     = '0;
      loaded    = 0;
      dropped   = 1'b0;
      errors    = 0;
      checked   = 0;
      strings   = 0;
      overflows = 0;
    endfunction

    // Symbols t with a rule t -> a b, a taken from lm and b from rm
    function logic [cyk_pkg::MASK_W-1:0] pair_mask(logic [cyk_pkg::MASK_W-1:0] lm,
                                                   logic [cyk_pkg::MASK_W-1:0] rm);
      logic [cyk_pkg::MASK_W-1:0] res;
      res = '0;
      for (int a = 0; a < 4; a++) begin
        for (int b = 0; b < 4; b++) begin
          if (lm[a] && rm[b]) begin
            for (int t = 0; t < 4; t++) begin
              if (rules[t*16 + a*4 + b]) res[t] = 1'b1;
            end
          end
        end
      end
      return res;
    endfunction

    // Fill spans bottom-up and return the mask of the whole string
    function logic [cyk_pkg::MASK_W-1:0] whole_mask(int unsigned n);
      logic [cyk_pkg::MASK_W-1:0] acc;
      for (int unsigned len = 1; len < n; len++) begin
        for (int unsigned lo = 0; lo + len < n; lo++) begin
          acc = '0;
          for (int unsigned m = lo; m < lo + len; m++) begin
            acc |= pair_mask(span[lo][m], span[m+1][lo+len]);
          end
          span[lo][lo+len] = acc;
        end
      end
      return span[0][n-1];
    endfunction

    function int unsigned pending();
      return verdict_q.size();
    endfunction

    // Store or drop an accepted symbol; queue a verdict on the last one
    function void note_symbol(cyk_pkg::in_item_t it);
      cyk_pkg::out_item_t want;
      if (loaded < MAX_SYMS) begin
        span[loaded][loaded] = 4'b0001 << it.symbol;
        loaded++;
      end else begin
        dropped = 1'b1;
      end
      if (it.last) begin
        want.letter_mask   = whole_mask(loaded);
        want.none_possible = (want.letter_mask == '0);
        want.overflow      = dropped;
        verdict_q.push_back(want);
        if (dropped) overflows++;
        strings++;
        loaded  = 0;
        dropped = 1'b0;
      end
    endfunction

    task report(string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      errors++;
    endtask

    // Compare an accepted result field by field with the oldest verdict
    task check_verdict(cyk_pkg::out_item_t got);
      cyk_pkg::out_item_t want;
      checked++;
      if (verdict_q.size() == 0) begin
        report($sformatf("result with nothing expected: mask %h", got.letter_mask));
      end else begin
        want = verdict_q.pop_front();
        if (got.letter_mask !== want.letter_mask)
          report($sformatf("letter_mask %h, expected %h", got.letter_mask,
                           want.letter_mask));
        if (got.none_possible !== want.none_possible)
          report($sformatf("none_possible %b, expected %b", got.none_possible,
                           want.none_possible));
        if (got.overflow !== want.overflow)
          report($sformatf("overflow %b, expected %b", got.overflow, want.overflow));
      end
    endtask
  endclass

  logic                       clk_i;
  logic                       rst_ni;
  logic                       cfg_valid_i;
  logic                       cfg_ready_o;
  logic [cyk_pkg::RULE_W-1:0] cfg_rule_table_i;
  logic                       in_valid_i;
  logic                       in_stall_o;
  cyk_pkg::in_item_t          in_item_i;
  logic                       out_valid_o;
  logic                       out_stall_i;
  cyk_pkg::out_item_t         out_item_o;

  verdict_board sb = new();
  int unsigned  burst_left   = 0;
  int unsigned  items_sent   = 0;
  int unsigned  rule_writes  = 0;
  int unsigned  long_strings = 0;
  int unsigned  rand_strings = 0;
  int unsigned  cycle_cnt    = 0;

  cyk_binary_grammar_recognizer_unit #(
    .MAX_LEN(MAX_SYMS)
  ) i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_rule_table_i(cfg_rule_table_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .in_item_i       (in_item_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_item_o      (out_item_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Check every accepted result
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_verdict(out_item_o);
  end

  // Stall the output on changing patterns; hold off once for a long stretch
  initial begin
    int unsigned mode;
    int unsigned mode_left;
    int unsigned hold_left;
    bit          hold_done;
    mode        = 0;
    mode_left   = 0;
    hold_left   = 0;
    hold_done   = 1'b0;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!hold_done && sb.checked >= HOLD_AFTER) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(50, 300);
        end
        mode_left--;
        case (mode)
          0: out_stall_i <= 1'b0;
          1: out_stall_i <= ($urandom_range(0, 9) < 3);
          2: out_stall_i <= (mode_left % 3 == 0);
          default: out_stall_i <= ($urandom_range(0, 9) < 7);
        endcase
      end
    end
  end

  // End the run at the cycle limit
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  // Write the rule register once the block has drained
  task automatic write_rules(input logic [cyk_pkg::RULE_W-1:0] value);
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
    cfg_valid_i      <= 1'b1;
    cfg_rule_table_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.rules = cfg_rule_table_i;
    rule_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Offer one symbol in bursts with random gaps; hold it until accepted
  task automatic send_symbol(input logic [1:0] sym, input logic fin);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 20) : $urandom_range(0, 3);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_item_i  <= '{symbol: sym, last: fin};
    do @(posedge clk_i); while (in_stall_o);
    sb.note_symbol(in_item_i);
    items_sent++;
    @(negedge clk_i);
  endtask

  function automatic logic [1:0] letter_code(byte c);
    case (c)
      "W": return LTR_W;
      "I": return LTR_I;
      "N": return LTR_N;
      default: return LTR_G;
    endcase
  endfunction

  task automatic send_word(input string w);
    for (int i = 0; i < w.len(); i++) send_symbol(letter_code(w[i]), i == w.len() - 1);
  endtask

  task automatic send_random(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) send_symbol(2'($urandom_range(0, 3)), i == len - 1);
  endtask

  // Mostly short strings; every sixtieth one at or beyond the maximum length
  function automatic int unsigned pick_len();
    int unsigned r;
    if (rand_strings % 60 == 30) begin
      long_strings++;
      if (long_strings == 1) return MAX_SYMS;
      if (long_strings == 2) return MAX_SYMS + 1;
      return $urandom_range(MAX_SYMS, MAX_SYMS + 6);
    end
    r = $urandom_range(0, 9);
    if (r < 3) return $urandom_range(1, 3);
    if (r < 9) return $urandom_range(4, 10);
    return $urandom_range(11, 16);
  endfunction

  initial begin
    logic [cyk_pkg::RULE_W-1:0] grammar;
    logic [cyk_pkg::RULE_W-1:0] phase_rules [RAND_PHASES];
    int unsigned                phase_start;
    rst_ni           = 1'b0;
    cfg_valid_i      = 1'b0;
    cfg_rule_table_i = '0;
    in_valid_i       = 1'b0;
    in_item_i        = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Empty grammar: single symbols map to themselves, longer strings to nothing
    write_rules('0);
    send_word("W");
    send_word("I");
    send_word("N");
    send_word("G");
    send_word("WI");

    // Full grammar: every symbol derives every string of two or more symbols
    write_rules('1);
    send_word("GGG");
    send_word("WING");

    // Small grammar: W -> I N, I -> N G, N -> W W, G -> W I, G -> G G
    grammar = '0;
    grammar[0*16 + 1*4 + 2] = 1'b1;
    grammar[1*16 + 2*4 + 3] = 1'b1;
    grammar[2*16 + 0*4 + 0] = 1'b1;
    grammar[3*16 + 0*4 + 1] = 1'b1;
    grammar[3*16 + 3*4 + 3] = 1'b1;
    write_rules(grammar);
    send_word("IN");
    send_word("WI");
    send_word("NGG");
    send_word("INWI");

    // Random strings under random, sparse, dense and extreme rule sets
    phase_rules[0] = {$urandom, $urandom};
    phase_rules[1] = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
    phase_rules[2] = {$urandom, $urandom} | {$urandom, $urandom};
    phase_rules[3] = {1'b1, {(cyk_pkg::RULE_W-2){1'b0}}, 1'b1};
    phase_rules[4] = grammar | {$urandom, $urandom} & {$urandom, $urandom};
    phase_rules[5] = '1;
    for (int p = 0; p < RAND_PHASES; p++) begin
      write_rules(phase_rules[p]);
      phase_start = items_sent;
      while (items_sent - phase_start < ITEM_TARGET / RAND_PHASES) begin
        send_random(pick_len());
        rand_strings++;
      end
    end
    in_valid_i <= 1'b0;

    // Drain, then allow the block to settle
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);

    $display("Covered %0d strings (%0d symbols, %0d at or past the length limit, %0d overflowed)",
             sb.strings, items_sent, long_strings, sb.overflows);
    $display("Checked %0d results under %0d rule settings in %0d cycles, %0d mismatches",
             sb.checked, rule_writes, cycle_cnt, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
